// ----- sv/rmrp_pkg.sv -----
// Shared types and constants of the rotation matrix to MRP converter.
// Used by every module of the block but rmrp_div; depends on nothing else.
package rmrp_pkg;

    localparam int DFLT_FRAC_BITS = 14;
    localparam int IN_W           = 16;
    localparam int EW             = IN_W + 2;
    localparam int FIFO_DEPTH     = 2;

    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } t_branch;

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } t_in_item;

    typedef struct packed {
        logic signed [IN_W-1:0] mrp_x;
        logic signed [IN_W-1:0] mrp_y;
        logic signed [IN_W-1:0] mrp_z;
    } t_out_item;

    typedef struct packed {
        t_branch              br;
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] d1;
        logic signed [EW-1:0] d2;
        logic signed [EW-1:0] d3;
    } t_cls_item;

endpackage

// ----- sv/rmrp_front.sv -----
// Front stage: accepts a matrix request and picks the Shepperd branch.
// Produces the diagonal combination and the three off-diagonal terms; uses rmrp_pkg.
module rmrp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rmrp_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rmrp_pkg::t_cls_item  o_item
);
    import rmrp_pkg::*;

    logic signed [EW-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, tr;
    t_cls_item n_item;
    t_cls_item r_item;
    logic      r_valid;

    assign c0 = EW'(i_item.m00);
    assign c1 = EW'(i_item.m01);
    assign c2 = EW'(i_item.m02);
    assign c3 = EW'(i_item.m10);
    assign c4 = EW'(i_item.m11);
    assign c5 = EW'(i_item.m12);
    assign c6 = EW'(i_item.m20);
    assign c7 = EW'(i_item.m21);
    assign c8 = EW'(i_item.m22);
    assign tr = c0 + c4 + c8;

    always_comb begin
        n_item = '0;
        priority if (tr > c0 && tr > c4 && tr > c8) begin
            n_item.br = BR_W;
            n_item.e  = tr;
            n_item.d1 = c5 - c7;
            n_item.d2 = c6 - c2;
            n_item.d3 = c1 - c3;
        end else if (c0 >= c4 && c0 >= c8) begin
            n_item.br = BR_X;
            n_item.e  = c0 - c4 - c8;
            n_item.d1 = c5 - c7;
            n_item.d2 = c1 + c3;
            n_item.d3 = c2 + c6;
        end else if (c4 >= c8) begin
            n_item.br = BR_Y;
            n_item.e  = c4 - c0 - c8;
            n_item.d1 = c6 - c2;
            n_item.d2 = c1 + c3;
            n_item.d3 = c5 + c7;
        end else begin
            n_item.br = BR_Z;
            n_item.e  = c8 - c0 - c4;
            n_item.d1 = c1 - c3;
            n_item.d2 = c2 + c6;
            n_item.d3 = c5 + c7;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- sv/rmrp_fifo.sv -----
// Short request queue between the front stage and the arithmetic pipeline.
// Depth comes from rmrp_pkg.
module rmrp_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rmrp_pkg::t_cls_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rmrp_pkg::t_cls_item  o_item
);
    import rmrp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_cls_item        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_ready = r_count != CNT_W'(FIFO_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("queue count exceeds depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on a lone push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> r_count == $past(r_count) - 1'b1)
        else $error("queue count did not shrink on a lone pop");

endmodule

// ----- sv/rmrp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Flags a quotient that does not fit in QW bits; stands alone.
module rmrp_div #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_ovf [QW+1];
    logic [CW-1:0] n_trial [QW];
    logic [QW-1:0] n_take;

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            n_trial[k-1] = CW'(r_den[k-1]) << (QW - k);
            n_take[k-1]  = r_rem[k-1] >= n_trial[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= CW'(i_num) >= (CW'(i_den) << QW);
            for (int k = 1; k < QW; k++) begin
                r_rem[k] <= n_take[k-1] ? r_rem[k-1] - n_trial[k-1] : r_rem[k-1];
                r_den[k] <= r_den[k-1];
            end
            for (int k = 1; k <= QW; k++) begin
                r_quo[k] <= r_quo[k-1] | (QW'(n_take[k-1]) << (QW - k));
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];

endmodule

// ----- sv/rmrp_back.sv -----
// Arithmetic pipeline: root, quaternion terms, sign, MRP division, shadow set.
// Uses rmrp_pkg and three banks of rmrp_div.
module rmrp_back #(
    parameter int FRAC_BITS = rmrp_pkg::DFLT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rmrp_pkg::t_cls_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rmrp_pkg::t_out_item  o_item
);
    import rmrp_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int AW  = ((F > 17) ? F : 17) + 3;
    localparam int AB  = AW - 1;
    localparam int XB  = AB + F - 2;
    localparam int QB  = (XB + 1) / 2;
    localparam int RW  = XB + 2;
    localparam int MW  = F + 2;
    localparam int QF  = F + 3;
    localparam int QX  = QB + MW;
    localparam int QW1 = MW;
    localparam int DW1 = QB + 2;
    localparam int NW1 = F + 18;
    localparam int QW2 = MW;
    localparam int DW2 = MW;
    localparam int NW2 = 2 * F + 3;
    localparam int PW  = 2 * MW;
    localparam int RB  = F + 4;
    localparam int QW3 = MW;
    localparam int NW3 = 2 * F + 3;
    localparam int SW  = QF + IN_W;
    localparam int L   = QB + QW1 + QW2 + QW3 + 9;
    localparam logic [MW-1:0] TWO_ONE = MW'(1) << (F + 1);
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

    logic         en;
    logic [L-1:0] r_vld;

    assign en      = !r_vld[L-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // Root stage.
    logic signed [AW-1:0] n_a;
    logic [AB-1:0]        n_a_cl;
    logic [RW-1:0]        r_sq_rem  [QB];
    logic [QB-1:0]        r_sq_root [QB+1];
    t_branch              r_sq_br   [QB+1];
    logic signed [EW-1:0] r_sq_d    [QB+1][3];
    logic [RW-1:0]        n_sq_trial [QB];
    logic [QB-1:0]        n_sq_take;

    assign n_a    = (AW'(1) << F) + AW'(i_item.e);
    assign n_a_cl = n_a[AW-1] ? '0 : n_a[AB-1:0];

    always_comb begin
        for (int k = 1; k <= QB; k++) begin
            n_sq_trial[k-1] = (RW'(r_sq_root[k-1]) << (QB - k + 1))
                            + (RW'(1) << (2 * (QB - k)));
            n_sq_take[k-1]  = r_sq_rem[k-1] >= n_sq_trial[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= RW'(n_a_cl) << (F - 2);
            r_sq_root[0] <= '0;
            r_sq_br[0]   <= i_item.br;
            r_sq_d[0][0] <= i_item.d1;
            r_sq_d[0][1] <= i_item.d2;
            r_sq_d[0][2] <= i_item.d3;
            for (int k = 1; k < QB; k++) begin
                r_sq_rem[k] <= n_sq_take[k-1] ? r_sq_rem[k-1] - n_sq_trial[k-1]
                                              : r_sq_rem[k-1];
            end
            for (int k = 1; k <= QB; k++) begin
                r_sq_root[k] <= r_sq_root[k-1] | (QB'(n_sq_take[k-1]) << (QB - k));
                r_sq_br[k]   <= r_sq_br[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_sq_d[k][i] <= r_sq_d[k-1][i];
                end
            end
        end
    end

    // Quaternion terms from the root.
    logic [QB-1:0]  sq_q;
    logic [EW-1:0]  n1_dmag [3];
    logic [NW1-1:0] n1_num  [3];
    logic [DW1-1:0] n1_den;
    logic [QW1-1:0] n1_quo  [3];
    logic           n1_ovf  [3];
    t_branch        r_c_br   [QW1+1];
    logic [QB-1:0]  r_c_qm   [QW1+1];
    logic [2:0]     r_c_neg  [QW1+1];
    logic           r_c_zero [QW1+1];

    assign sq_q   = r_sq_root[QB];
    assign n1_den = DW1'(sq_q) << 2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_dmag[i] = r_sq_d[QB][i][EW-1] ? EW'(-r_sq_d[QB][i]) : EW'(r_sq_d[QB][i]);
            n1_num[i]  = (NW1'(n1_dmag[i]) << F) + (NW1'(sq_q) << 1);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div1
        rmrp_div #(.NW(NW1), .DW(DW1), .QW(QW1)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n1_num[g]),
            .i_den (n1_den),
            .o_quo (n1_quo[g]),
            .o_ovf (n1_ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_br[0]   <= r_sq_br[QB];
            r_c_qm[0]   <= sq_q;
            r_c_neg[0]  <= {r_sq_d[QB][2][EW-1], r_sq_d[QB][1][EW-1], r_sq_d[QB][0][EW-1]};
            r_c_zero[0] <= sq_q == '0;
            for (int k = 1; k <= QW1; k++) begin
                r_c_br[k]   <= r_c_br[k-1];
                r_c_qm[k]   <= r_c_qm[k-1];
                r_c_neg[k]  <= r_c_neg[k-1];
                r_c_zero[k] <= r_c_zero[k-1];
            end
        end
    end

    // Quaternion assembly, clamp and sign.
    logic [MW-1:0]        n2_tmag [3];
    logic signed [QF-1:0] n2_t    [3];
    logic [MW-1:0]        n2_mmag;
    logic signed [QF-1:0] n2_m;
    logic signed [QF-1:0] n2_q    [4];
    logic signed [QF-1:0] r2_q    [4];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_c_zero[QW1]) begin
                n2_tmag[i] = '0;
            end else if (n1_ovf[i] || n1_quo[i] > TWO_ONE) begin
                n2_tmag[i] = TWO_ONE;
            end else begin
                n2_tmag[i] = n1_quo[i];
            end
            n2_t[i] = r_c_neg[QW1][i] ? -QF'(n2_tmag[i]) : QF'(n2_tmag[i]);
        end
        n2_mmag = (QX'(r_c_qm[QW1]) > QX'(TWO_ONE)) ? TWO_ONE : MW'(r_c_qm[QW1]);
        n2_m    = QF'(n2_mmag);
        n2_q[0] = n2_m;
        n2_q[1] = n2_t[0];
        n2_q[2] = n2_t[1];
        n2_q[3] = n2_t[2];
        unique case (r_c_br[QW1])
            BR_W: begin
                n2_q[0] = n2_m;
                n2_q[1] = n2_t[0];
                n2_q[2] = n2_t[1];
                n2_q[3] = n2_t[2];
            end
            BR_X: begin
                n2_q[0] = n2_t[0];
                n2_q[1] = n2_m;
                n2_q[2] = n2_t[1];
                n2_q[3] = n2_t[2];
            end
            BR_Y: begin
                n2_q[0] = n2_t[0];
                n2_q[1] = n2_t[1];
                n2_q[2] = n2_m;
                n2_q[3] = n2_t[2];
            end
            BR_Z: begin
                n2_q[0] = n2_t[0];
                n2_q[1] = n2_t[1];
                n2_q[2] = n2_t[2];
                n2_q[3] = n2_m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r2_q[i] <= n2_q[0][QF-1] ? -n2_q[i] : n2_q[i];
            end
        end
    end

    // Division by one plus the scalar part.
    logic [DW2-1:0] n3_den;
    logic [MW-1:0]  n3_mag [3];
    logic [NW2-1:0] n3_num [3];
    logic [QW2-1:0] n3_quo [3];
    logic           n3_ovf [3];
    logic [2:0]     r_e_neg [QW2+1];

    assign n3_den = (DW2'(1) << F) + DW2'(r2_q[0]);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_mag[i] = r2_q[i+1][QF-1] ? MW'(-r2_q[i+1]) : MW'(r2_q[i+1]);
            n3_num[i] = (NW2'(n3_mag[i]) << F) + NW2'(n3_den >> 1);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div2
        rmrp_div #(.NW(NW2), .DW(DW2), .QW(QW2)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n3_num[g]),
            .i_den (n3_den),
            .o_quo (n3_quo[g]),
            .o_ovf (n3_ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_neg[0] <= {r2_q[3][QF-1], r2_q[2][QF-1], r2_q[1][QF-1]};
            for (int k = 1; k <= QW2; k++) begin
                r_e_neg[k] <= r_e_neg[k-1];
            end
        end
    end

    // Squared norm and shadow set test.
    logic [MW-1:0]  r3_mag [3];
    logic [2:0]     r3_neg;
    logic [PW-1:0]  r4_sq  [3];
    logic [MW-1:0]  r4_mag [3];
    logic [2:0]     r4_neg;
    logic [PW-1:0]  n5_ss;
    logic [MW-1:0]  r5_mag [3];
    logic [2:0]     r5_neg;
    logic           r5_shadow;
    logic [RB-1:0]  r5_r;

    assign n5_ss = r4_sq[0] + r4_sq[1] + r4_sq[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r3_mag[i] <= n3_ovf[i] ? TWO_ONE : n3_quo[i];
                r4_sq[i]  <= PW'(r3_mag[i]) * PW'(r3_mag[i]);
                r4_mag[i] <= r3_mag[i];
                r5_mag[i] <= r4_mag[i];
            end
            r3_neg    <= r_e_neg[QW2];
            r4_neg    <= r3_neg;
            r5_neg    <= r4_neg;
            r5_shadow <= n5_ss > (PW'(1) << (2 * F));
            r5_r      <= RB'(n5_ss >> F);
        end
    end

    // Shadow set division.
    logic [NW3-1:0] n6_num [3];
    logic [QW3-1:0] n6_quo [3];
    logic           n6_ovf [3];
    logic [MW-1:0]  r_f_mag [QW3+1][3];
    logic [2:0]     r_f_neg [QW3+1];
    logic           r_f_sh  [QW3+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n6_num[i] = (NW3'(r5_mag[i]) << F) + NW3'(r5_r >> 1);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div3
        rmrp_div #(.NW(NW3), .DW(RB), .QW(QW3)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n6_num[g]),
            .i_den (r5_r),
            .o_quo (n6_quo[g]),
            .o_ovf (n6_ovf[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_mag[0][i] <= r5_mag[i];
            end
            r_f_neg[0] <= r5_neg;
            r_f_sh[0]  <= r5_shadow;
            for (int k = 1; k <= QW3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_f_mag[k][i] <= r_f_mag[k-1][i];
                end
                r_f_neg[k] <= r_f_neg[k-1];
                r_f_sh[k]  <= r_f_sh[k-1];
            end
        end
    end

    // Output saturation and register.
    logic [MW-1:0]          n7_quo [3];
    logic signed [QF-1:0]   n7_v   [3];
    logic signed [SW-1:0]   n7_w   [3];
    logic signed [IN_W-1:0] n7_o   [3];
    t_out_item              r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n7_quo[i] = n6_ovf[i] ? TWO_ONE : n6_quo[i];
            if (r_f_sh[QW3]) begin
                n7_v[i] = r_f_neg[QW3][i] ? QF'(n7_quo[i]) : -QF'(n7_quo[i]);
            end else begin
                n7_v[i] = r_f_neg[QW3][i] ? -QF'(r_f_mag[QW3][i]) : QF'(r_f_mag[QW3][i]);
            end
            n7_w[i] = SW'(n7_v[i]);
            if (n7_w[i] > SAT_HI) begin
                n7_o[i] = 16'sh7fff;
            end else if (n7_w[i] < SAT_LO) begin
                n7_o[i] = 16'sh8000;
            end else begin
                n7_o[i] = n7_w[i][IN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.mrp_x <= n7_o[0];
            r_out.mrp_y <= n7_o[1];
            r_out.mrp_z <= n7_o[2];
        end
    end

    assign o_item = r_out;

endmodule

// ----- sv/rotation_matrix_to_mrp_core.sv -----
// Rotation matrix to modified Rodrigues parameters converter, top level.
// Instantiates rmrp_front, rmrp_fifo and rmrp_back; uses rmrp_pkg.
//
// Input channel: i_valid / o_ready carry one 3x3 matrix request per
// transfer in i_item, each entry signed with FRAC_BITS fraction bits.
// Output channel: o_valid / i_ready carry one result request, the three
// MRP components in o_item with the same scaling.
// A new matrix is taken every cycle while results are drained. From
// acceptance to o_valid a request passes the front register, the queue
// and the back pipeline, whose length is set by the bit-per-stage root
// pipeline, with a root QB bits wide (16 at FRAC_BITS = 14), and the three
// bit-per-stage divider banks.
// When the receiver stalls, the pipeline holds in place; the two-entry
// queue and the front register keep taking requests until they are full.
// Reset empties the front register, the queue and the pipeline; no request
// is in flight afterwards.
module rotation_matrix_to_mrp_core #(
    parameter int FRAC_BITS = rmrp_pkg::DFLT_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rmrp_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rmrp_pkg::t_out_item  o_item
);
    import rmrp_pkg::*;

    logic      fr_valid, fr_ready, q_valid, q_ready;
    t_cls_item fr_item, q_item;

    rmrp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (fr_valid),
        .i_ready (fr_ready),
        .o_item  (fr_item)
    );

    rmrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    rmrp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule
